// File: rtl/tpa_pkg.sv
// ---------------------------------------------------------------------------
// Tick prescaler with periodic alarms: shared package
// Types, register indexes and constants that the modules of the block share.
// ---------------------------------------------------------------------------
package tpa_pkg;

	// Number of periodic alarm slots.
	localparam int ALARM_SLOTS = 8;

	// Field widths, fixed by the interface.
	localparam int SLOT_W   = 3;
	localparam int PERIOD_W = 24;
	localparam int WORD_W   = 32;
	localparam int TICK_W   = 64;
	localparam int MASK_W   = 8;

	// Period in ticks: (Q16.8 period * frequency) >> 8 always fits in 48 bits.
	localparam int FRAC_W = 8;
	localparam int PROD_W = PERIOD_W + WORD_W;
	localparam int PT_W   = PROD_W - FRAC_W;

	// Division by 1000 as a multiplication by a reciprocal. The quotient is
	// exact for every 32-bit dividend.
	localparam int                 RECIP_W  = 29;
	localparam logic [RECIP_W-1:0] MS_RECIP = 29'h10624DD3;
	localparam int                 MS_SHIFT = 38;

	localparam logic [WORD_W-1:0] FREQ_RESET = 32'd1000;
	localparam logic [WORD_W-1:0] MS_RELOAD_RESET = 32'd1;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_ARM  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		REG_TICK_FREQUENCY    = 2'd0,
		REG_TIMER_ENABLE      = 2'd1,
		REG_START_TIME_OF_DAY = 2'd2
	} cfg_reg_t;

	// One item held in the input register.
	typedef struct packed {
		op_t               op;
		logic [SLOT_W-1:0] slot;
		logic [PT_W-1:0]   period_ticks;
	} item_t;

	// What the item leaving the input register does to the state this cycle.
	typedef struct packed {
		logic do_tick;
		logic do_arm;
	} step_t;

	// A configuration write as seen by the register block.
	typedef struct packed {
		logic              we;
		cfg_reg_t          index;
		logic [WORD_W-1:0] data;
	} cfg_wr_t;

	// Frequency divided by 1000.
	function automatic logic [WORD_W-1:0] ms_reload_of(input logic [WORD_W-1:0] freq);
		logic [WORD_W+RECIP_W-1:0] prod;
		prod = {{RECIP_W{1'b0}}, freq} * {{WORD_W{1'b0}}, MS_RECIP};
		return WORD_W'(prod >> MS_SHIFT);
	endfunction

endpackage

// File: rtl/tpa_input_stage.sv
// ---------------------------------------------------------------------------
// Input register
// Captures one item per transfer and converts the alarm period to ticks.
// ---------------------------------------------------------------------------
module tpa_input_stage (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  logic                         drain,
	input  logic                         op,
	input  logic [tpa_pkg::SLOT_W-1:0]   alarm_slot,
	input  logic [tpa_pkg::PERIOD_W-1:0] alarm_period_q8,
	input  logic [tpa_pkg::WORD_W-1:0]   freq,
	output logic                         valid_s1,
	output tpa_pkg::item_t               item_s1
);
	import tpa_pkg::*;

	logic [PROD_W-1:0] prod;

	// User must change the frequency only while the block is idle; unenforced.
	assign prod = {{WORD_W{1'b0}}, alarm_period_q8} * {{PERIOD_W{1'b0}}, freq};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (drain) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.op           <= op_t'(op);
			item_s1.slot         <= alarm_slot;
			item_s1.period_ticks <= prod[PROD_W-1:FRAC_W];
		end
	end

endmodule

// File: rtl/tpa_alarm_bank.sv
// ---------------------------------------------------------------------------
// Alarm bank
// Per-slot deadline and period registers, due compares and re-arming.
// ---------------------------------------------------------------------------
module tpa_alarm_bank (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tpa_pkg::step_t             step,
	input  tpa_pkg::item_t             item_s1,
	input  logic [tpa_pkg::TICK_W-1:0] tick,
	output logic [tpa_pkg::MASK_W-1:0] fired
);
	import tpa_pkg::*;

	logic [TICK_W-1:0] deadline_q [ALARM_SLOTS];
	logic [PT_W-1:0]   period_q   [ALARM_SLOTS];
	logic [ALARM_SLOTS-1:0] active_q;
	logic [ALARM_SLOTS-1:0] due;
	logic [ALARM_SLOTS-1:0] arm_sel;

	for (genvar i = 0; i < ALARM_SLOTS; i++) begin : g_slot
		assign due[i]     = step.do_tick && active_q[i] && (tick >= deadline_q[i]);
		assign arm_sel[i] = step.do_arm && (32'(item_s1.slot) == i);

		always_ff @(posedge clk) begin
			if (arm_sel[i]) begin
				period_q[i]   <= item_s1.period_ticks;
				deadline_q[i] <= tick + {{(TICK_W-PT_W){1'b0}}, item_s1.period_ticks};
			end else if (due[i]) begin
				deadline_q[i] <= tick + {{(TICK_W-PT_W){1'b0}}, period_q[i]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				active_q[i] <= 1'b0;
			end else if (arm_sel[i]) begin
				active_q[i] <= 1'b1;
			end
		end
	end

	// Only the first eight slots have a bit in the mask.
	for (genvar b = 0; b < MASK_W; b++) begin : g_mask
		if (b < ALARM_SLOTS) begin : g_live
			assign fired[b] = due[b];
		end else begin : g_none
			assign fired[b] = 1'b0;
		end
	end

endmodule

// File: rtl/tpa_counters.sv
// ---------------------------------------------------------------------------
// Configuration registers and counters
// Holds the registers, both prescalers and the tick, ms, second and
// time-of-day counters.
// ---------------------------------------------------------------------------
module tpa_counters (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tpa_pkg::cfg_wr_t           cfg,
	input  tpa_pkg::step_t             step,
	output logic [tpa_pkg::WORD_W-1:0] freq,
	output logic                       enable,
	output logic [tpa_pkg::WORD_W-1:0] ms_count,
	output logic [tpa_pkg::WORD_W-1:0] sec_count,
	output logic [tpa_pkg::WORD_W-1:0] wall,
	output logic [tpa_pkg::TICK_W-1:0] tick
);
	import tpa_pkg::*;

	logic [WORD_W-1:0] freq_q, ms_reload_q, ms_pre_q, sec_pre_q;
	logic [WORD_W-1:0] ms_cnt_q, sec_cnt_q, wall_q;
	logic [TICK_W-1:0] tick_q;
	logic              enable_q;
	logic              ms_wrap, sec_wrap;
	logic              wr_freq, wr_enable, wr_tod;
	logic [WORD_W-1:0] new_ms_reload;

	always_comb begin
		wr_freq   = 1'b0;
		wr_enable = 1'b0;
		wr_tod    = 1'b0;
		if (cfg.we) begin
			unique case (cfg.index)
				REG_TICK_FREQUENCY:    wr_freq   = 1'b1;
				REG_TIMER_ENABLE:      wr_enable = 1'b1;
				REG_START_TIME_OF_DAY: wr_tod    = 1'b1;
				default: ;
			endcase
		end
	end

	assign new_ms_reload = ms_reload_of(cfg.data);
	assign ms_wrap  = (ms_pre_q == '0);
	assign sec_wrap = (sec_pre_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q      <= FREQ_RESET;
			ms_reload_q <= MS_RELOAD_RESET;
			ms_pre_q    <= MS_RELOAD_RESET;
			sec_pre_q   <= FREQ_RESET;
			tick_q      <= '0;
			enable_q    <= 1'b0;
			ms_cnt_q    <= '0;
			sec_cnt_q   <= '0;
			wall_q      <= '0;
		end else begin
			if (wr_freq) begin
				freq_q      <= cfg.data;
				ms_reload_q <= new_ms_reload;
				ms_pre_q    <= new_ms_reload;
				sec_pre_q   <= cfg.data;
				tick_q      <= '0;
			end else if (step.do_tick) begin
				ms_pre_q  <= (ms_wrap ? ms_reload_q : ms_pre_q) - 1'b1;
				sec_pre_q <= (sec_wrap ? freq_q : sec_pre_q) - 1'b1;
				tick_q    <= tick_q + 1'b1;
			end
			if (wr_enable) begin
				enable_q <= cfg.data[0];
			end
			if (step.do_tick && ms_wrap) begin
				ms_cnt_q <= ms_cnt_q + 1'b1;
			end
			if (step.do_tick && sec_wrap) begin
				sec_cnt_q <= sec_cnt_q + 1'b1;
			end
			if (wr_tod) begin
				wall_q <= cfg.data;
			end else if (step.do_tick && sec_wrap) begin
				wall_q <= wall_q + 1'b1;
			end
		end
	end

	assign freq      = freq_q;
	assign enable    = enable_q;
	assign ms_count  = ms_cnt_q;
	assign sec_count = sec_cnt_q;
	assign wall      = wall_q;
	assign tick      = tick_q;

`ifndef ASSERT_OFF
	a_tick_step: assert property (@(posedge clk) disable iff (!arst_n)
		step.do_tick && !wr_freq |=> tick_q == $past(tick_q) + 1'b1)
		else $error("tick counter did not advance on an enabled tick");

	a_freq_reload: assert property (@(posedge clk) disable iff (!arst_n)
		wr_freq |=> tick_q == '0 && sec_pre_q == freq_q && ms_pre_q == ms_reload_q)
		else $error("frequency write did not reload the prescalers");
`endif

endmodule

// File: rtl/tick_prescaler_with_periodic_alarms.sv
// ---------------------------------------------------------------------------
// Tick prescaler with periodic alarms
// Tick-driven timer with millisecond and second prescalers, a time-of-day
// counter and a bank of periodic alarm slots.
// ---------------------------------------------------------------------------
//
// Channel   Signals                                       Direction  Handshake
// input     op, alarm_slot, alarm_period_q8               in         in_valid / in_stall
// result    fired_mask, millisecond_count, second_count,  out        out_valid / out_stall
//           time_of_day, tick_count
// config    cfg_index, cfg_data                           in         cfg_valid / cfg_ready
//
// An item passes from transfer to result through the input register,
// where the alarm period is multiplied into ticks, and then through the alarm
// compares and counter adds into the state and result registers. One item is
// taken every cycle while the input side is not stalled; the period multiplier
// and the eight 64-bit deadline compares set the cycle length.
// Reset is asynchronous and active low; it needs no clearing pass.
// A stall on the result side holds the result and, once the input register is
// also full, stalls the input side in the same cycle.
//
module tick_prescaler_with_periodic_alarms (
	input  logic                         clk,
	input  logic                         arst_n,
	// input channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         op,
	input  logic [tpa_pkg::SLOT_W-1:0]   alarm_slot,
	input  logic [tpa_pkg::PERIOD_W-1:0] alarm_period_q8,
	// result channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [tpa_pkg::MASK_W-1:0]   fired_mask,
	output logic [tpa_pkg::WORD_W-1:0]   millisecond_count,
	output logic [tpa_pkg::WORD_W-1:0]   second_count,
	output logic [tpa_pkg::WORD_W-1:0]   time_of_day,
	output logic [tpa_pkg::TICK_W-1:0]   tick_count,
	// configuration channel
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [1:0]                   cfg_index,
	input  logic [tpa_pkg::WORD_W-1:0]   cfg_data
);
	import tpa_pkg::*;

	logic              valid_s1;
	item_t             item_s1;
	logic              load, move, out_free;
	step_t             step;
	cfg_wr_t           cfg;
	logic [WORD_W-1:0] freq;
	logic              enable;
	logic [MASK_W-1:0] fired;
	logic [MASK_W-1:0] fired_q;
	logic              out_valid_q;
	logic [TICK_W-1:0] tick;

	// The result register is free when it is empty or its transfer completes
	// this cycle. The item in the input register moves on whenever it is free,
	// and the input side is stalled only while both stages are held.
	assign out_free = !out_valid_q || !out_stall;
	assign move     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign load     = in_valid && !in_stall;

	// Configuration writes are always taken; the user must send them only while idle, which the block does not enforce.
	assign cfg_ready = 1'b1;
	assign cfg.we    = cfg_valid;
	assign cfg.index = cfg_reg_t'(cfg_index);
	assign cfg.data  = cfg_data;

	// A tick acts only when the timer is enabled; a set-up always arms.
	assign step.do_tick = move && (item_s1.op == OP_TICK) && enable;
	assign step.do_arm  = move && (item_s1.op == OP_ARM);

	tpa_input_stage u_input (
		.clk             (clk),
		.arst_n          (arst_n),
		.load            (load),
		.drain           (move),
		.op              (op),
		.alarm_slot      (alarm_slot),
		.alarm_period_q8 (alarm_period_q8),
		.freq            (freq),
		.valid_s1        (valid_s1),
		.item_s1         (item_s1)
	);

	// The alarm bank reads the tick count before this item's increment, which
	// is the order in which the slots are checked and re-armed.
	tpa_alarm_bank u_alarms (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.item_s1 (item_s1),
		.tick    (tick),
		.fired   (fired)
	);

	tpa_counters u_counters (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (step),
		.freq      (freq),
		.enable    (enable),
		.ms_count  (millisecond_count),
		.sec_count (second_count),
		.wall      (time_of_day),
		.tick      (tick)
	);

	// The counters are updated in the same edge that loads the result, and
	// only a configuration write changes them before that result has been
	// transferred, so they serve directly as the counter fields of the result
	// register. Only the fired mask needs a register of its own.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			fired_q <= fired;
		end
	end

	assign out_valid  = out_valid_q;
	assign fired_mask = fired_q;
	assign tick_count = tick;

`ifndef ASSERT_OFF
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled while a stage was free");

	a_result_holds_counters: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall && !cfg_valid |=> out_valid_q && $stable(tick)
			&& $stable(time_of_day))
		else $error("counters changed under a held result");

	a_fire_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		move && (fired != '0) |-> step.do_tick)
		else $error("alarm fired on an item that is not an enabled tick");
`endif

endmodule
